// File: hdl/skf_pkg.sv
// shared types, constants and helpers for the scalar kalman filter unit
package skf_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned VAR_W = 31;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QUO_W = DATA_W + FRAC_W;

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ESTIMATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VARIANCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSERVATION_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 3'd5;

  localparam logic signed [DATA_W-1:0] RST_INIT_ESTIMATE    = 32'sh0000_0000;
  localparam logic [VAR_W-1:0]         RST_INIT_VARIANCE    = 31'd65536;
  localparam logic signed [DATA_W-1:0] RST_TRANSITION_GAIN  = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] RST_OBSERVATION_GAIN = 32'sh0001_0000;
  localparam logic [VAR_W-1:0]         RST_PROCESS_NOISE    = 31'd524;
  localparam logic [VAR_W-1:0]         RST_MEASUREMENT_NOISE = 31'd45875;

  typedef struct packed {
    logic signed [DATA_W-1:0] measurement;
    logic                     restart;
  } skf_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] estimate;
    logic signed [DATA_W-1:0] variance;
    logic signed [DATA_W-1:0] kalman_gain;
    logic                     divide_fault;
  } skf_out_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] numerator;
    logic signed [DATA_W-1:0] denominator;
  } skf_div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quotient;
  } skf_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X,
    ST_AA,
    ST_P,
    ST_PH,
    ST_DEN,
    ST_DIV,
    ST_INNOV,
    ST_XUP,
    ST_OM,
    ST_PUP,
    ST_DONE
  } skf_state_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_X,
    DST_P,
    DST_PH,
    DST_TMP
  } skf_dst_t;

  // clamp a wide signed value into 32 bits
  function automatic logic signed [DATA_W-1:0] sat48(input logic signed [QUO_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[QUO_W-1:DATA_W-1] == '0 || v[QUO_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[QUO_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: hdl/skf_div.sv
// radix-2 restoring divider for the q16.16 gain, one quotient bit per cycle
module skf_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  skf_pkg::skf_div_req_t req,
  output skf_pkg::skf_div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(skf_pkg::QUO_W);

  logic                          busy_r;
  logic                          done_r;
  logic                          neg_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [skf_pkg::QUO_W-1:0]     dq_r;
  logic [skf_pkg::DATA_W-1:0]    d_r;
  logic [skf_pkg::DATA_W-1:0]    rem_r;
  logic [skf_pkg::DATA_W-1:0]    num_abs;
  logic [skf_pkg::DATA_W-1:0]    den_abs;
  logic [skf_pkg::DATA_W:0]      shifted;
  logic [skf_pkg::DATA_W+1:0]    diff;
  logic                          qbit;
  logic signed [skf_pkg::DATA_W-1:0] quo;

  assign num_abs = req.numerator[skf_pkg::DATA_W-1] ? -req.numerator : req.numerator;
  assign den_abs = req.denominator[skf_pkg::DATA_W-1] ? -req.denominator : req.denominator;
  assign shifted = {rem_r, dq_r[skf_pkg::QUO_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d_r};
  assign qbit    = !diff[skf_pkg::DATA_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(skf_pkg::QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.numerator[skf_pkg::DATA_W-1] ^ req.denominator[skf_pkg::DATA_W-1];
      dq_r  <= {num_abs, {skf_pkg::FRAC_W{1'b0}}};
      d_r   <= den_abs;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[skf_pkg::DATA_W-1:0] : shifted[skf_pkg::DATA_W-1:0];
      dq_r  <= {dq_r[skf_pkg::QUO_W-2:0], qbit};
    end
  end

  // saturate the magnitude, then apply the sign
  always_comb begin
    if (dq_r[skf_pkg::QUO_W-1:skf_pkg::DATA_W-1] != '0) begin
      quo = neg_r ? {1'b1, {(skf_pkg::DATA_W-1){1'b0}}} : {1'b0, {(skf_pkg::DATA_W-1){1'b1}}};
    end else begin
      quo = neg_r ? -dq_r[skf_pkg::DATA_W-1:0] : dq_r[skf_pkg::DATA_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start && cnt_r == '0 |=> done_r) else $error("divider missed done");
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");

endmodule

// File: hdl/scalar_kalman_filter_unit.sv
// scalar kalman filter unit: sequencer, shared multiplier and state registers
// When the gain denominator is zero the division is skipped and a divide fault
// is flagged. Nine Q16.16 products run one after another on a single 32x32
// multiplier, each a registered multiply then shift, saturate and add or
// subtract, and the gain division runs in a one-bit-per-cycle divider.
// in_ready is high only while the unit is idle. A finished result is held in
// the output register; the next word may be accepted while it waits, and the
// unit stalls before its own result only if the previous one is still not
// taken. Configuration writes are accepted every cycle and take effect at
// once, so they belong between words while nothing is in flight. Products
// round toward minus infinity and every intermediate value saturates to 32 bits.
module scalar_kalman_filter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  skf_pkg::skf_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output skf_pkg::skf_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]         cfg_data
);

  localparam int unsigned W  = skf_pkg::DATA_W;
  localparam int unsigned QW = skf_pkg::QUO_W;

  skf_pkg::skf_state_t state_r, state_nxt;
  logic                phase_r, phase_nxt;

  logic signed [W-1:0]            init_estimate_r;
  logic [skf_pkg::VAR_W-1:0]      init_variance_r;
  logic signed [W-1:0]            transition_gain_r;
  logic signed [W-1:0]            observation_gain_r;
  logic [skf_pkg::VAR_W-1:0]      process_noise_r;
  logic [skf_pkg::VAR_W-1:0]      measurement_noise_r;

  logic signed [W-1:0]   est_r;
  logic signed [W-1:0]   var_r;
  logic signed [W-1:0]   x_r;
  logic signed [W-1:0]   p_r;
  logic signed [W-1:0]   ph_r;
  logic signed [W-1:0]   tmp_r;
  logic signed [W-1:0]   gain_r;
  logic signed [W-1:0]   z_r;
  logic                  fault_r;
  logic signed [2*W-1:0] prod_r;

  logic                 out_valid_r;
  skf_pkg::skf_out_t    out_data_r;

  logic signed [W-1:0]  mul_a;
  logic signed [W-1:0]  mul_b;
  logic signed [W-1:0]  wb_add;
  logic                 wb_sub;
  skf_pkg::skf_dst_t    wb_dst;
  logic                 fault_set;
  logic                 gain_load;
  logic                 out_load;
  logic                 accept;

  logic signed [W-1:0]  qm;
  logic signed [QW-1:0] qm_ext;
  logic signed [QW-1:0] add_ext;
  logic signed [QW-1:0] sum;
  logic signed [W-1:0]  wb_val;

  skf_pkg::skf_div_req_t div_req;
  skf_pkg::skf_div_rsp_t div_rsp;

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // product post-processing: shift, saturate, add or subtract, saturate
  assign qm      = skf_pkg::sat48(prod_r[2*W-1:skf_pkg::FRAC_W]);
  assign qm_ext  = QW'(qm);
  assign add_ext = QW'(wb_add);
  assign sum     = wb_sub ? add_ext - qm_ext : add_ext + qm_ext;
  assign wb_val  = skf_pkg::sat48(sum);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      skf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = skf_pkg::ST_X;
          phase_nxt = 1'b0;
        end
      end
      skf_pkg::ST_DIV: begin
        if (!phase_r) begin
          if (tmp_r == '0) begin
            state_nxt = skf_pkg::ST_INNOV;
          end else begin
            phase_nxt = 1'b1;
          end
        end else if (div_rsp.done) begin
          state_nxt = skf_pkg::ST_INNOV;
          phase_nxt = 1'b0;
        end
      end
      skf_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          case (state_r)
            skf_pkg::ST_X:     state_nxt = skf_pkg::ST_AA;
            skf_pkg::ST_AA:    state_nxt = skf_pkg::ST_P;
            skf_pkg::ST_P:     state_nxt = skf_pkg::ST_PH;
            skf_pkg::ST_PH:    state_nxt = skf_pkg::ST_DEN;
            skf_pkg::ST_DEN:   state_nxt = skf_pkg::ST_DIV;
            skf_pkg::ST_INNOV: state_nxt = skf_pkg::ST_XUP;
            skf_pkg::ST_XUP:   state_nxt = skf_pkg::ST_OM;
            skf_pkg::ST_OM:    state_nxt = skf_pkg::ST_PUP;
            skf_pkg::ST_PUP:   state_nxt = skf_pkg::ST_DONE;
            default:           state_nxt = skf_pkg::ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    wb_add    = '0;
    wb_sub    = 1'b0;
    wb_dst    = skf_pkg::DST_NONE;
    fault_set = 1'b0;
    gain_load = 1'b0;
    out_load  = 1'b0;
    in_ready  = 1'b0;
    div_req.start       = 1'b0;
    div_req.numerator   = ph_r;
    div_req.denominator = tmp_r;
    case (state_r)
      skf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      skf_pkg::ST_X: begin
        mul_a = transition_gain_r;
        mul_b = est_r;
        wb_dst = phase_r ? skf_pkg::DST_X : skf_pkg::DST_NONE;
      end
      skf_pkg::ST_AA: begin
        mul_a = transition_gain_r;
        mul_b = transition_gain_r;
        wb_dst = phase_r ? skf_pkg::DST_TMP : skf_pkg::DST_NONE;
      end
      skf_pkg::ST_P: begin
        mul_a  = tmp_r;
        mul_b  = var_r;
        wb_add = W'({1'b0, process_noise_r});
        wb_dst = phase_r ? skf_pkg::DST_P : skf_pkg::DST_NONE;
      end
      skf_pkg::ST_PH: begin
        mul_a = p_r;
        mul_b = observation_gain_r;
        wb_dst = phase_r ? skf_pkg::DST_PH : skf_pkg::DST_NONE;
      end
      skf_pkg::ST_DEN: begin
        mul_a  = ph_r;
        mul_b  = observation_gain_r;
        wb_add = W'({1'b0, measurement_noise_r});
        wb_dst = phase_r ? skf_pkg::DST_TMP : skf_pkg::DST_NONE;
      end
      skf_pkg::ST_DIV: begin
        if (!phase_r) begin
          fault_set     = (tmp_r == '0);
          div_req.start = (tmp_r != '0);
        end else begin
          gain_load = div_rsp.done;
        end
      end
      skf_pkg::ST_INNOV: begin
        mul_a  = observation_gain_r;
        mul_b  = x_r;
        wb_add = z_r;
        wb_sub = 1'b1;
        wb_dst = phase_r ? skf_pkg::DST_TMP : skf_pkg::DST_NONE;
      end
      skf_pkg::ST_XUP: begin
        mul_a  = gain_r;
        mul_b  = tmp_r;
        wb_add = x_r;
        wb_dst = phase_r ? skf_pkg::DST_X : skf_pkg::DST_NONE;
      end
      skf_pkg::ST_OM: begin
        mul_a  = gain_r;
        mul_b  = observation_gain_r;
        wb_add = skf_pkg::Q_ONE;
        wb_sub = 1'b1;
        wb_dst = phase_r ? skf_pkg::DST_TMP : skf_pkg::DST_NONE;
      end
      skf_pkg::ST_PUP: begin
        mul_a = tmp_r;
        mul_b = p_r;
        wb_dst = phase_r ? skf_pkg::DST_P : skf_pkg::DST_NONE;
      end
      skf_pkg::ST_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= skf_pkg::ST_IDLE;
      phase_r             <= 1'b0;
      out_valid_r         <= 1'b0;
      est_r               <= skf_pkg::RST_INIT_ESTIMATE;
      var_r               <= W'({1'b0, skf_pkg::RST_INIT_VARIANCE});
      init_estimate_r     <= skf_pkg::RST_INIT_ESTIMATE;
      init_variance_r     <= skf_pkg::RST_INIT_VARIANCE;
      transition_gain_r   <= skf_pkg::RST_TRANSITION_GAIN;
      observation_gain_r  <= skf_pkg::RST_OBSERVATION_GAIN;
      process_noise_r     <= skf_pkg::RST_PROCESS_NOISE;
      measurement_noise_r <= skf_pkg::RST_MEASUREMENT_NOISE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && in_data.restart) begin
        est_r <= init_estimate_r;
        var_r <= W'({1'b0, init_variance_r});
      end else if (out_load) begin
        est_r <= x_r;
        var_r <= p_r;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          skf_pkg::CFG_INIT_ESTIMATE:     init_estimate_r     <= cfg_data;
          skf_pkg::CFG_INIT_VARIANCE:     init_variance_r     <= cfg_data[skf_pkg::VAR_W-1:0];
          skf_pkg::CFG_TRANSITION_GAIN:   transition_gain_r   <= cfg_data;
          skf_pkg::CFG_OBSERVATION_GAIN:  observation_gain_r  <= cfg_data;
          skf_pkg::CFG_PROCESS_NOISE:     process_noise_r     <= cfg_data[skf_pkg::VAR_W-1:0];
          skf_pkg::CFG_MEASUREMENT_NOISE: measurement_noise_r <= cfg_data[skf_pkg::VAR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (accept) begin
      z_r     <= in_data.measurement;
      fault_r <= 1'b0;
      gain_r  <= '0;
    end
    if (fault_set) begin
      fault_r <= 1'b1;
      gain_r  <= '0;
    end
    if (gain_load) begin
      gain_r <= div_rsp.quotient;
    end
    case (wb_dst)
      skf_pkg::DST_X:   x_r   <= wb_val;
      skf_pkg::DST_P:   p_r   <= wb_val;
      skf_pkg::DST_PH:  ph_r  <= wb_val;
      skf_pkg::DST_TMP: tmp_r <= wb_val;
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r.estimate     <= x_r;
      out_data_r.variance     <= p_r;
      out_data_r.kalman_gain  <= gain_r;
      out_data_r.divide_fault <= fault_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready) else $error("ready after accepting a word");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> tmp_r != '0) else $error("divider started on zero denominator");
  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == skf_pkg::ST_DIV && phase_r)
    else $error("divider result arrived outside the gain step");
  a_fault_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_fault |-> out_data.kalman_gain == '0)
    else $error("divide fault with nonzero gain");

endmodule
